// File: src/lrcc_pkg.sv
// Shared constants for the left-right disparity consistency checker.
// Holds field widths, default sizes, register indexes and result codes.
// No dependencies; lrcc_proj and lr_consistency_check refer to it by scoped name.
`default_nettype none

package lrcc_pkg;

  // Default sizes of the row stores and the fixed-point format.
  localparam int MAX_WIDTH_DEFAULT     = 4096;
  localparam int FRACTION_BITS_DEFAULT = 4;

  // Fixed widths of the interface fields.
  localparam int DISP_W   = 16;
  localparam int COLUMN_W = 12;
  localparam int THRESH_W = 16;
  localparam int ROWW_W   = 13;
  localparam int CFG_W    = 16;

  // Configuration register indexes.
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_ROW_WIDTH = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd16;
  localparam logic [ROWW_W-1:0]   ROW_WIDTH_RESET = 13'd640;

  // Input item kinds.
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // Pixel classes reported with each check result.
  localparam logic [1:0] CLASS_CONSISTENT = 2'd0;
  localparam logic [1:0] CLASS_OCCLUSION  = 2'd1;
  localparam logic [1:0] CLASS_MISMATCH   = 2'd2;

endpackage

`default_nettype wire

// File: src/lrcc_ram.sv
// Single-port row store with registered read data.
// Read data holds its value in cycles without a read. Uses no package items.
`default_nettype none

module lrcc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 17
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: src/lrcc_proj.sv
// Shared projection unit: round(base +/- offset / 2^FRACTION_BITS) with rounding
// half away from zero, plus a range check against the active row width.
// Depends on lrcc_pkg for the disparity and row-width field widths.
`default_nettype none

module lrcc_proj #(
  parameter int MAX_WIDTH     = lrcc_pkg::MAX_WIDTH_DEFAULT,
  parameter int FRACTION_BITS = lrcc_pkg::FRACTION_BITS_DEFAULT,
  localparam int AW   = $clog2(MAX_WIDTH),
  localparam int WW   = ($clog2(MAX_WIDTH + 1) > lrcc_pkg::ROWW_W) ?
                        $clog2(MAX_WIDTH + 1) : lrcc_pkg::ROWW_W
) (
  input  wire logic                              [AW-1:0] base,
  input  wire logic signed [lrcc_pkg::DISP_W-1:0]         offset,
  input  wire logic                                       subtract,
  input  wire logic                              [WW-1:0] width,
  output logic                                   [AW-1:0] index,
  output logic                                            in_range
);

  localparam int SW   = AW + FRACTION_BITS;
  localparam int VW   = ((SW > lrcc_pkg::DISP_W) ? SW : lrcc_pkg::DISP_W) + 2;
  localparam int CMPW = (VW > WW) ? VW : WW;
  localparam logic [VW-1:0] HALF = VW'((1 << FRACTION_BITS) >> 1);

  logic signed [VW-1:0] scaled;
  logic signed [VW-1:0] off_ext;
  logic signed [VW-1:0] sum;
  logic signed [VW-1:0] rounded;
  logic        [VW-1:0] mag;
  logic        [VW-1:0] rmag;

  assign scaled  = $signed({{(VW - AW){1'b0}}, base} << FRACTION_BITS);
  assign off_ext = VW'(offset);
  assign sum     = subtract ? (scaled - off_ext) : (scaled + off_ext);

  // Round the magnitude, then restore the sign.
  assign mag     = sum[VW-1] ? $unsigned(-sum) : $unsigned(sum);
  assign rmag    = (mag + HALF) >> FRACTION_BITS;
  assign rounded = sum[VW-1] ? -$signed(rmag) : $signed(rmag);

  assign index    = rounded[AW-1:0];
  assign in_range = !rounded[VW-1] && (CMPW'($unsigned(rounded)) < CMPW'(width));

endmodule

`default_nettype wire

// File: src/lr_consistency_check.sv
// Top level of the left-right disparity consistency checker for one row.
// Uses lrcc_pkg, lrcc_ram (two row stores) and lrcc_proj (shared projection).
`default_nettype none

// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+---------------------------------
// input     | in        | in_valid / in_stall     | kind, column, left_disparity,
//           |           |                         | left_valid, right_disparity,
//           |           |                         | right_valid
// result    | out       | out_valid / out_stall   | result_column, result_disparity,
//           |           |                         | result_valid, pixel_class
// config    | in        | cfg_write (no handshake)| cfg_index, cfg_data
//
// A store transfer is taken in S_IDLE and the next item can follow at once.
// A check holds off the next item until it ends, after up to three dependent
// row-store reads (own left, projected right, back-projected left) through
// single-port memories.
// Reset (rst, synchronous) clears the sequencer, the result valid flag and the
// configuration registers; the row stores and the result payload are not cleared.
// A check may start while a finished result still waits; the check then holds
// in its last step until the result register frees up.

module lr_consistency_check #(
  parameter int MAX_WIDTH     = lrcc_pkg::MAX_WIDTH_DEFAULT,
  parameter int FRACTION_BITS = lrcc_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,

  input  wire logic                                       cfg_write,
  input  wire logic                                       cfg_index,
  input  wire logic              [lrcc_pkg::CFG_W-1:0]    cfg_data,

  input  wire logic                                       in_valid,
  output logic                                            in_stall,
  input  wire logic                                       kind,
  input  wire logic              [lrcc_pkg::COLUMN_W-1:0] column,
  input  wire logic signed       [lrcc_pkg::DISP_W-1:0]   left_disparity,
  input  wire logic                                       left_valid,
  input  wire logic signed       [lrcc_pkg::DISP_W-1:0]   right_disparity,
  input  wire logic                                       right_valid,

  output logic                                            out_valid,
  input  wire logic                                       out_stall,
  output logic                   [lrcc_pkg::COLUMN_W-1:0] result_column,
  output logic signed            [lrcc_pkg::DISP_W-1:0]   result_disparity,
  output logic                                            result_valid,
  output logic                   [1:0]                    pixel_class
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > lrcc_pkg::ROWW_W) ?
                      $clog2(MAX_WIDTH + 1) : lrcc_pkg::ROWW_W;
  localparam int DW = lrcc_pkg::DISP_W;
  localparam int EW = DW + 1;   // store entry: valid bit over disparity

  typedef enum logic [1:0] {
    S_IDLE,
    S_OWN,
    S_RIGHT,
    S_BACK
  } state_t;

  // Configuration registers.
  logic [lrcc_pkg::THRESH_W-1:0] threshold;
  logic [lrcc_pkg::ROWW_W-1:0]   row_width;

  // Sequencer state and per-check registers.
  state_t                         state;
  state_t                         state_next;
  logic [lrcc_pkg::COLUMN_W-1:0]  col_q;
  logic                           col_in;
  logic signed [DW-1:0]           d_q;
  logic [AW-1:0]                  cr_q;

  // Active row width: row_width capped at the store depth.
  logic [WW-1:0] active_width;
  logic [WW-1:0] column_ext;
  logic          in_accept;
  logic          store_ok;
  logic          can_emit;

  // Row store ports.
  logic          left_we;
  logic          left_re;
  logic [AW-1:0] left_addr;
  logic [EW-1:0] left_wdata;
  logic [EW-1:0] left_rdata;
  logic          right_we;
  logic          right_re;
  logic [AW-1:0] right_addr;
  logic [EW-1:0] right_rdata;

  // Shared projection unit ports.
  logic [AW-1:0]        proj_base;
  logic signed [DW-1:0] proj_offset;
  logic                 proj_subtract;
  logic [AW-1:0]        proj_index;
  logic                 proj_in_range;

  // Views of the read data and the consistency compare.
  logic signed [DW-1:0] own_d;
  logic                 own_ok;
  logic signed [DW-1:0] right_d;
  logic                 right_ok;
  logic signed [DW-1:0] back_d;
  logic                 back_ok;
  logic signed [DW:0]   diff;
  logic        [DW:0]   diff_abs;
  logic                 keep;

  // Result produced this cycle.
  logic                 emit;
  logic                 emit_keep;
  logic [1:0]           emit_class;
  logic                 clear_own;

  assign active_width = (WW'(row_width) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(row_width);
  assign column_ext   = WW'(column);
  assign in_accept    = in_valid && !in_stall;
  assign in_stall     = (state != S_IDLE);
  assign store_ok     = (column_ext < WW'(MAX_WIDTH));
  assign can_emit     = !out_valid || !out_stall;

  assign own_d    = $signed(left_rdata[DW-1:0]);
  assign own_ok   = left_rdata[DW];
  assign back_d   = $signed(left_rdata[DW-1:0]);
  assign back_ok  = left_rdata[DW];
  assign right_d  = $signed(right_rdata[DW-1:0]);
  assign right_ok = right_rdata[DW];

  assign diff     = EW'(d_q) - EW'(right_d);
  assign diff_abs = diff[DW] ? $unsigned(-diff) : $unsigned(diff);
  assign keep     = (diff_abs <= EW'(threshold));

  // The projection unit serves the forward projection (column minus own
  // disparity) in S_OWN and the back-projection (right column plus right
  // disparity) in S_RIGHT.
  always_comb begin
    if (state == S_RIGHT) begin
      proj_base     = cr_q;
      proj_offset   = right_d;
      proj_subtract = 1'b0;
    end else begin
      proj_base     = col_q[AW-1:0];
      proj_offset   = own_d;
      proj_subtract = 1'b1;
    end
  end

  lrcc_proj #(
    .MAX_WIDTH     (MAX_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_proj (
    .base     (proj_base),
    .offset   (proj_offset),
    .subtract (proj_subtract),
    .width    (active_width),
    .index    (proj_index),
    .in_range (proj_in_range)
  );

  // Sequencer decisions. A step that finishes a check waits in place while
  // the result register is still full; no memory access happens meanwhile,
  // so the registered read data stays valid.
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_keep  = 1'b0;
    emit_class = lrcc_pkg::CLASS_MISMATCH;
    clear_own  = 1'b0;
    left_re    = 1'b0;
    right_re   = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_accept && kind == lrcc_pkg::KIND_CHECK) begin
          left_re    = 1'b1;
          state_next = S_OWN;
        end
      end

      S_OWN: begin
        if (col_in && own_ok && proj_in_range) begin
          right_re   = 1'b1;
          state_next = S_RIGHT;
        end else if (can_emit) begin
          emit       = 1'b1;
          // A valid own disparity whose projection leaves the row is rejected.
          clear_own  = col_in && own_ok;
          state_next = S_IDLE;
        end
      end

      S_RIGHT: begin
        if (right_ok && !keep && proj_in_range) begin
          left_re    = 1'b1;
          state_next = S_BACK;
        end else if (can_emit) begin
          emit       = 1'b1;
          emit_keep  = right_ok && keep;
          emit_class = (right_ok && keep) ? lrcc_pkg::CLASS_CONSISTENT :
                                            lrcc_pkg::CLASS_MISMATCH;
          clear_own  = !(right_ok && keep);
          state_next = S_IDLE;
        end
      end

      S_BACK: begin
        if (can_emit) begin
          emit       = 1'b1;
          // An invalid back-projected entry counts as a larger disparity.
          emit_class = (!back_ok || back_d > d_q) ? lrcc_pkg::CLASS_OCCLUSION :
                                                    lrcc_pkg::CLASS_MISMATCH;
          clear_own  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Left store: written by store transfers and by rejections (valid bit
  // cleared), read at the own column and at the back-projected column.
  always_comb begin
    left_we    = 1'b0;
    left_addr  = col_q[AW-1:0];
    left_wdata = {1'b0, d_q};
    if (state == S_IDLE) begin
      left_addr  = column_ext[AW-1:0];
      left_wdata = {left_valid, left_disparity};
      left_we    = in_accept && kind == lrcc_pkg::KIND_STORE && store_ok;
    end else if (state == S_OWN) begin
      left_wdata = {1'b0, own_d};
      left_we    = clear_own;
    end else if (state == S_RIGHT && left_re) begin
      left_addr = proj_index;
    end else begin
      left_we = clear_own;
    end
  end

  // Right store: written by store transfers, read at the projected column.
  assign right_we   = (state == S_IDLE) && in_accept &&
                      kind == lrcc_pkg::KIND_STORE && store_ok;
  assign right_addr = (state == S_IDLE) ? column_ext[AW-1:0] : proj_index;

  lrcc_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (EW)
  ) u_left_store (
    .clk   (clk),
    .we    (left_we),
    .re    (left_re),
    .addr  (left_addr),
    .wdata (left_wdata),
    .rdata (left_rdata)
  );

  lrcc_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (EW)
  ) u_right_store (
    .clk   (clk),
    .we    (right_we),
    .re    (right_re),
    .addr  (right_addr),
    .wdata ({right_valid, right_disparity}),
    .rdata (right_rdata)
  );

  // State, per-check registers, configuration and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      threshold <= lrcc_pkg::THRESHOLD_RESET;
      row_width <= lrcc_pkg::ROW_WIDTH_RESET;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        if (cfg_index == lrcc_pkg::CFG_THRESHOLD) begin
          threshold <= cfg_data[lrcc_pkg::THRESH_W-1:0];
        end else begin
          row_width <= cfg_data[lrcc_pkg::ROWW_W-1:0];
        end
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end

    if (state == S_IDLE && in_accept) begin
      col_q  <= column;
      col_in <= (column_ext < active_width);
    end
    if (state == S_OWN) begin
      d_q  <= own_d;
      cr_q <= proj_index;
    end

    if (emit) begin
      result_column    <= col_q;
      result_disparity <= emit_keep ? d_q : '0;
      result_valid     <= emit_keep;
      pixel_class      <= emit_class;
    end
  end

endmodule

`default_nettype wire
